// File: rtl/wvat_pkg.sv
`timescale 1ns / 1ps
// Package for the wind vane / anemometer tick unit: widths, constants,
// vane threshold tables and the direction lookup. No dependencies.
package wvat_pkg;

  localparam int SumW    = 16;
  localparam int PeriodW = 16;
  localparam int AvgW    = 10;
  localparam int SpeedW  = 16;
  localparam int DirW    = 13;
  localparam int SpaW    = 7;
  localparam int LimitW  = 8;
  localparam int IdleW   = 10;
  localparam int CfgW    = 8;
  localparam int DivW    = 22;
  localparam int CntW    = 5;
  localparam int NumDir  = 16;

  localparam logic CFG_SAMPLES    = 1'b0;
  localparam logic CFG_IDLE_LIMIT = 1'b1;

  localparam logic [SpaW-1:0]   SpaReset   = SpaW'(32);
  localparam logic [LimitW-1:0] LimitReset = LimitW'(20);
  localparam logic [IdleW-1:0]  IdleReset  = IdleW'(1000);

  localparam logic [DivW-1:0]   SpeedNum   = DivW'(2400000);
  localparam logic [AvgW-1:0]   AvgMax     = AvgW'(1023);
  localparam logic [SpeedW-1:0] SpeedMax   = SpeedW'(65535);
  localparam logic [AvgW-1:0]   AvgValidMax = AvgW'(984);
  localparam logic signed [DirW-1:0] DirInvalid = -DirW'(1);

  localparam logic [AvgW-1:0] DirThreshold [NumDir] = '{
    AvgW'(916), AvgW'(857), AvgW'(807), AvgW'(744),
    AvgW'(666), AvgW'(614), AvgW'(530), AvgW'(433),
    AvgW'(346), AvgW'(265), AvgW'(214), AvgW'(155),
    AvgW'(109), AvgW'(88),  AvgW'(75),  AvgW'(33)
  };

  localparam logic signed [DirW-1:0] DirValue [NumDir] = '{
    DirW'(2700), DirW'(3150), DirW'(2925), DirW'(0),
    DirW'(3375), DirW'(2250), DirW'(2475), DirW'(450),
    DirW'(225),  DirW'(1800), DirW'(2025), DirW'(1350),
    DirW'(1575), DirW'(900),  DirW'(675),  DirW'(1125)
  };

  // First threshold the average exceeds wins.
  function automatic logic signed [DirW-1:0] vane_direction(input logic [AvgW-1:0] avg);
    logic signed [DirW-1:0] dir;
    dir = DirInvalid;
    if (avg <= AvgValidMax) begin
      for (int i = NumDir - 1; i >= 0; i--) begin
        if (avg > DirThreshold[i]) begin
          dir = DirValue[i];
        end
      end
    end
    return dir;
  endfunction

endpackage

// File: rtl/wvat_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the tick unit input and result beats.
// Depends on wvat_pkg.
interface wvat_in_if import wvat_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SumW-1:0]    adc_sample_sum;
  logic               new_rotation;
  logic [PeriodW-1:0] rotation_period_ms;

  modport source (output valid, adc_sample_sum, new_rotation, rotation_period_ms,
                  input ready);
  modport sink   (input valid, adc_sample_sum, new_rotation, rotation_period_ms,
                  output ready);
endinterface

interface wvat_out_if import wvat_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [PeriodW-1:0]     period_report_ms;
  logic [AvgW-1:0]        adc_average;
  logic [SpeedW-1:0]      wind_speed_cms;
  logic signed [DirW-1:0] wind_direction;

  modport source (output valid, period_report_ms, adc_average, wind_speed_cms,
                  wind_direction, input ready);
  modport sink   (input valid, period_report_ms, adc_average, wind_speed_cms,
                  wind_direction, output ready);
endinterface

// File: rtl/wind_vane_anemometer_tick_unit.sv
`timescale 1ns / 1ps
// Wind vane / anemometer tick unit: ADC averaging, vane lookup, wind speed.
// Depends on wvat_pkg and the channel interfaces in wvat_if.sv.
//
// channel   dir  signals                                         beat
// in_i      in   adc_sample_sum, new_rotation, rotation_period_ms one tick
// out_o     out  period_report_ms, adc_average, wind_speed_cms,   one result
//                wind_direction
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i                  one register
//
// One restoring divider (22 steps, one quotient bit per cycle) does both
// divisions in turn. A tick runs the average division, then the speed
// division when a rotation with a nonzero period needs it.
// Reset: samples 32, idle limit 20, speed 0, idle count 1000.
// in_i.ready is high only while the sequencer is idle; the result register
// holds a beat until taken, and a finished tick waits for it to drain.
module wind_vane_anemometer_tick_unit import wvat_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  wvat_in_if.sink         in_i,
  wvat_out_if.source      out_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AVG  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_SPD  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [CntW-1:0] CntLast = CntW'(DivW - 1);

  logic [2:0]         state_q, state_d;
  logic [SpaW-1:0]    spa_q;
  logic [LimitW-1:0]  limit_q;
  logic [SpeedW-1:0]  held_q, held_d;
  logic [IdleW-1:0]   idle_q, idle_d;

  logic               fresh_q;
  logic [PeriodW-1:0] period_q;
  logic [AvgW-1:0]    avg_q;

  logic [DivW-1:0]    quo_q, quo_d;
  logic [DivW-1:0]    rem_q, rem_d;
  logic [DivW-1:0]    dvs_q, dvs_d;
  logic [CntW-1:0]    cnt_q, cnt_d;

  logic                   ovld_q;
  logic [PeriodW-1:0]     orep_q;
  logic [AvgW-1:0]        oavg_q;
  logic [SpeedW-1:0]      ospd_q;
  logic signed [DirW-1:0] odir_q;

  logic [DivW:0]      shifted;
  logic [DivW+1:0]    trial;
  logic [DivW-1:0]    step_rem, step_quo;
  logic [DivW-1:0]    period_x36;
  logic [SpeedW-1:0]  speed;
  logic               accept, out_free, load_out;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !ovld_q || out_o.ready;
  assign load_out = (state_q == S_FIN) && out_free;

  assign in_i.ready = (state_q == S_IDLE);

  // shared restoring divider step
  assign shifted = {rem_q, quo_q[DivW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
  always_comb begin
    if (!trial[DivW+1]) begin
      step_rem = trial[DivW-1:0];
      step_quo = {quo_q[DivW-2:0], 1'b1};
    end else begin
      step_rem = shifted[DivW-1:0];
      step_quo = {quo_q[DivW-2:0], 1'b0};
    end
  end

  assign period_x36 = ({(DivW-PeriodW)'(0), period_q} << 5)
                    + ({(DivW-PeriodW)'(0), period_q} << 2);

  always_comb begin
    if (period_q == '0) begin
      speed = '0;
    end else if (quo_q > {(DivW-SpeedW)'(0), SpeedMax}) begin
      speed = SpeedMax;
    end else begin
      speed = quo_q[SpeedW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    held_d  = held_q;
    idle_d  = idle_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          quo_d   = {(DivW-SumW)'(0), in_i.adc_sample_sum};
          rem_d   = '0;
          dvs_d   = {(DivW-SpaW)'(0), spa_q};
          cnt_d   = '0;
          state_d = S_AVG;
        end
      end
      S_AVG, S_SPD: begin
        quo_d = step_quo;
        rem_d = step_rem;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntLast) begin
          state_d = (state_q == S_AVG) ? S_LOAD : S_FIN;
        end
      end
      S_LOAD: begin
        quo_d = SpeedNum;
        rem_d = '0;
        dvs_d = period_x36;
        cnt_d = '0;
        state_d = (fresh_q && period_q != '0) ? S_SPD : S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
          if (fresh_q) begin
            held_d = speed;
            idle_d = '0;
          end else if (idle_q > {(IdleW-LimitW)'(0), limit_q}) begin
            held_d = '0;
            idle_d = '0;
          end else begin
            idle_d = idle_q + IdleW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      spa_q   <= SpaReset;
      limit_q <= LimitReset;
      held_q  <= '0;
      idle_q  <= IdleReset;
      ovld_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      idle_q  <= idle_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SAMPLES:    spa_q   <= cfg_data_i[SpaW-1:0];
          CFG_IDLE_LIMIT: limit_q <= cfg_data_i[LimitW-1:0];
          default: ;
        endcase
      end
      if (load_out) begin
        ovld_q <= 1'b1;
      end else if (out_o.ready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    if (accept) begin
      fresh_q  <= in_i.new_rotation;
      period_q <= in_i.rotation_period_ms;
    end
    if (state_q == S_LOAD) begin
      // zero sample count divides to all ones and saturates too
      avg_q <= (quo_q > {(DivW-AvgW)'(0), AvgMax}) ? AvgMax : quo_q[AvgW-1:0];
    end
    if (load_out) begin
      orep_q <= fresh_q ? period_q : '0;
      oavg_q <= avg_q;
      ospd_q <= held_d;
      odir_q <= vane_direction(avg_q);
    end
  end

  assign out_o.valid            = ovld_q;
  assign out_o.period_report_ms = orep_q;
  assign out_o.adc_average      = oavg_q;
  assign out_o.wind_speed_cms   = ospd_q;
  assign out_o.wind_direction   = odir_q;

endmodule
